[hw/rtl/brm_pkg.sv]
package brm_pkg;

    localparam int CNT_W   = 64;
    localparam int TIME_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int ACC_W   = 56;
    localparam int OUT_W   = 40;
    localparam int ALPHA_W = 17;
    localparam int WIN_W   = 16;
    localparam int IDLE_W  = 8;
    localparam int SCALE_W = 10;
    localparam int PROD_W  = CNT_W + SCALE_W;
    localparam int DVD_W   = PROD_W + FRAC_W;
    localparam int MULQ_W  = ALPHA_W + ACC_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [SCALE_W-1:0] MS_PER_S   = SCALE_W'(1000);
    localparam logic [ALPHA_W-1:0] ONE_Q16    = ALPHA_W'(65536);
    localparam logic [IDLE_W-1:0]  IDLE_SAT   = '1;
    localparam logic [ACC_W-1:0]   ACC_MAX    = '1;
    localparam logic [OUT_W-1:0]   OUT_MAX    = '1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd2;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [WIN_W-1:0]   WINDOW_RST = WIN_W'(250);
    localparam logic [IDLE_W-1:0]  IDLE_RST   = IDLE_W'(4);
    localparam logic [ALPHA_W-1:0] ALPHA_RST  = ALPHA_W'(19661);

    typedef struct packed {
        logic              command;
        logic [CNT_W-1:0]  byte_count;
        logic [TIME_W-1:0] timestamp_ms;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] smoothed_rate;
        logic             rate_valid;
        logic [OUT_W-1:0] average_rate;
        logic             average_valid;
    } out_item_t;

    // classified item handed from front to engine
    typedef struct packed {
        logic              clear;
        logic [CNT_W-1:0]  cnt;
        logic [TIME_W-1:0] now;
    } brm_item_t;

    typedef struct packed {
        logic [WIN_W-1:0]   window_ms;
        logic [IDLE_W-1:0]  idle_limit;
        logic [ALPHA_W-1:0] alpha;
    } brm_cfg_t;

endpackage

[hw/rtl/byte_rate_meter_ema.sv]
// Channel   Dir  Handshake             Payload
// in        in   in_valid / in_stall   in_item (command, byte_count, timestamp_ms)
// out       out  out_valid / out_stall out_item (smoothed_rate, rate_valid,
//                                      average_rate, average_valid)
// cfg       in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item in flight in the engine; up to two more wait in the front queue.
// Engine loop: a clear or a sample that needs no divide runs decode, average check, output.
// Each divide adds multiply, start, the two-bit steps and done, and a blend adds its two
// products and their sum, so the worst sample does window rate, blend and average.
// rst_n is asynchronous and clears all tracking state and loads register defaults.
// A stalled output holds its transaction; the engine finishes the next item and waits.
module byte_rate_meter_ema
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  brm_pkg::in_item_t                  in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output brm_pkg::out_item_t                 out_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [brm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [brm_pkg::ALPHA_W-1:0]        cfg_data
);

    brm_pkg::brm_cfg_t  cfg_reg;
    brm_pkg::brm_item_t q_item;
    logic               q_valid;
    logic               q_ready;

    // config writes are always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ms  <= brm_pkg::WINDOW_RST;
            cfg_reg.idle_limit <= brm_pkg::IDLE_RST;
            cfg_reg.alpha      <= brm_pkg::ALPHA_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                brm_pkg::REG_WINDOW: cfg_reg.window_ms  <= cfg_data[brm_pkg::WIN_W-1:0];
                brm_pkg::REG_IDLE:   cfg_reg.idle_limit <= cfg_data[brm_pkg::IDLE_W-1:0];
                brm_pkg::REG_ALPHA:  cfg_reg.alpha      <= cfg_data;
                default:
                begin
                    // unmapped index: write ignored
                end
            endcase
        end
    end

    // front: accepts and classifies transactions into a short queue
    brm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // back: tracker state, rate divide, smoothing blend, result register
    brm_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

[hw/rtl/brm_front.sv]
module brm_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  brm_pkg::in_item_t   in_item,
    output logic                q_valid,
    input  logic                q_ready,
    output brm_pkg::brm_item_t  q_item
);

    brm_pkg::brm_item_t fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_stall = (count_reg == 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg].clear <= (in_item.command == brm_pkg::CMD_CLEAR);
            fifo_reg[wr_ptr_reg].cnt   <= in_item.byte_count;
            fifo_reg[wr_ptr_reg].now   <= in_item.timestamp_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[hw/rtl/brm_divider.sv]
module brm_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [brm_pkg::DVD_W-1:0]     dividend,
    input  logic [brm_pkg::TIME_W-1:0]    divisor,
    output logic                          done,
    output logic [brm_pkg::ACC_W-1:0]     quotient,
    output logic                          overflow
);

    // two restoring steps per cycle
    localparam int STEPS = brm_pkg::DVD_W / 2;
    localparam int CW    = $clog2(STEPS);

    logic [brm_pkg::DVD_W-1:0]  dvd_reg;
    logic [brm_pkg::TIME_W-1:0] den_reg;
    logic [brm_pkg::TIME_W-1:0] rem_reg;
    logic [brm_pkg::ACC_W-1:0]  q_reg;
    logic                       ovf_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [brm_pkg::TIME_W:0]   t1;
    logic [brm_pkg::TIME_W:0]   t2;
    logic [brm_pkg::TIME_W-1:0] r1;
    logic [brm_pkg::TIME_W-1:0] r2;
    logic                       b1;
    logic                       b2;

    always_comb
    begin
        t1 = {rem_reg, dvd_reg[brm_pkg::DVD_W-1]};
        b1 = (t1 >= {1'b0, den_reg});
        r1 = b1 ? brm_pkg::TIME_W'(t1 - {1'b0, den_reg}) : t1[brm_pkg::TIME_W-1:0];
        t2 = {r1, dvd_reg[brm_pkg::DVD_W-2]};
        b2 = (t2 >= {1'b0, den_reg});
        r2 = b2 ? brm_pkg::TIME_W'(t2 - {1'b0, den_reg}) : t2[brm_pkg::TIME_W-1:0];
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign overflow = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dvd_reg  <= dividend;
                den_reg  <= divisor;
                rem_reg  <= '0;
                q_reg    <= '0;
                ovf_reg  <= 1'b0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                dvd_reg <= {dvd_reg[brm_pkg::DVD_W-3:0], 2'b00};
                rem_reg <= r2;
                q_reg   <= {q_reg[brm_pkg::ACC_W-3:0], b1, b2};
                // any bit pushed out of the top means saturation
                ovf_reg <= ovf_reg || q_reg[brm_pkg::ACC_W-1] || q_reg[brm_pkg::ACC_W-2];
                if (cnt_reg == CW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
        end
    end

endmodule

[hw/rtl/brm_engine.sv]
module brm_engine
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  brm_pkg::brm_cfg_t    cfg,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  brm_pkg::brm_item_t   q_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output brm_pkg::out_item_t   out_item
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_DGO  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_BL1  = 4'd5;
    localparam logic [3:0] S_BL2  = 4'd6;
    localparam logic [3:0] S_BL3  = 4'd7;
    localparam logic [3:0] S_AVG  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam int CW = brm_pkg::CNT_W;
    localparam int TW = brm_pkg::TIME_W;
    localparam int AW = brm_pkg::ACC_W;

    logic [3:0]               state_reg;
    brm_pkg::brm_item_t       item_reg;

    logic                     prev_primed_reg;
    logic [CW-1:0]            prev_count_reg;
    logic                     avg_started_reg;
    logic [CW-1:0]            avg_base_count_reg;
    logic [TW-1:0]            avg_base_time_reg;
    logic [CW-1:0]            avg_last_count_reg;
    logic [TW-1:0]            avg_last_time_reg;
    logic                     win_primed_reg;
    logic [CW-1:0]            win_last_count_reg;
    logic [TW-1:0]            win_last_time_reg;
    logic                     seeded_reg;
    logic [brm_pkg::IDLE_W-1:0] idle_reg;
    logic [AW-1:0]            acc_reg;

    logic [CW-1:0]            num_reg;
    logic [TW-1:0]            den_reg;
    logic                     scaled_reg;
    logic                     is_avg_reg;
    logic [brm_pkg::PROD_W-1:0] prod_reg;
    logic [AW-1:0]            bx_reg;
    logic [brm_pkg::MULQ_W-1:0] p1_reg;
    logic [brm_pkg::MULQ_W-1:0] p2_reg;
    logic [brm_pkg::OUT_W-1:0]  avg_res_reg;
    logic                     avg_ok_reg;
    logic                     out_valid_reg;
    brm_pkg::out_item_t       out_item_reg;

    logic [TW-1:0]            ms;
    logic [TW-1:0]            win;
    logic [CW-1:0]            delta;
    logic [brm_pkg::IDLE_W-1:0] idle_inc;
    logic [brm_pkg::ALPHA_W-1:0] a_clamp;
    logic [brm_pkg::ALPHA_W-1:0] b_wt;
    logic [TW-1:0]            el;
    logic [brm_pkg::DVD_W-1:0] dividend;
    logic                     div_start;
    logic                     div_done;
    logic [AW-1:0]            div_q;
    logic                     div_ovf;
    logic [AW-1:0]            inst;
    logic                     out_free;
    logic [brm_pkg::MULQ_W:0] bl_sum;

    always_comb
    begin
        ms       = item_reg.now - win_last_time_reg;
        win      = (cfg.window_ms == '0) ? TW'(1) : TW'(cfg.window_ms);
        delta    = item_reg.cnt - win_last_count_reg;
        idle_inc = (idle_reg != brm_pkg::IDLE_SAT) ? idle_reg + 1'b1 : idle_reg;
        a_clamp  = (cfg.alpha > brm_pkg::ONE_Q16) ? brm_pkg::ONE_Q16 : cfg.alpha;
        b_wt     = brm_pkg::ONE_Q16 - a_clamp;
        el       = avg_last_time_reg - avg_base_time_reg;
        dividend = scaled_reg ? {prod_reg, brm_pkg::FRAC_W'(0)}
                              : {brm_pkg::FRAC_W'(0), prod_reg};
        inst     = div_ovf ? brm_pkg::ACC_MAX : div_q;
        bl_sum   = {1'b0, p1_reg} + {1'b0, p2_reg};
    end

    assign q_ready   = (state_reg == S_IDLE);
    assign div_start = (state_reg == S_DGO);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    brm_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q),
        .overflow (div_ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            item_reg           <= '0;
            prev_primed_reg    <= 1'b0;
            prev_count_reg     <= '0;
            avg_started_reg    <= 1'b0;
            avg_base_count_reg <= '0;
            avg_base_time_reg  <= '0;
            avg_last_count_reg <= '0;
            avg_last_time_reg  <= '0;
            win_primed_reg     <= 1'b0;
            win_last_count_reg <= '0;
            win_last_time_reg  <= '0;
            seeded_reg         <= 1'b0;
            idle_reg           <= '0;
            acc_reg            <= '0;
            num_reg            <= '0;
            den_reg            <= '0;
            scaled_reg         <= 1'b0;
            is_avg_reg         <= 1'b0;
            prod_reg           <= '0;
            bx_reg             <= '0;
            p1_reg             <= '0;
            p2_reg             <= '0;
            avg_res_reg        <= '0;
            avg_ok_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_item_reg       <= '0;
        end
        else
        begin
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg  <= q_item;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    state_reg <= S_AVG;
                    if (item_reg.clear)
                    begin
                        prev_primed_reg    <= 1'b0;
                        prev_count_reg     <= '0;
                        avg_started_reg    <= 1'b0;
                        avg_base_count_reg <= '0;
                        avg_base_time_reg  <= '0;
                        avg_last_count_reg <= '0;
                        avg_last_time_reg  <= '0;
                        win_primed_reg     <= 1'b0;
                        win_last_count_reg <= '0;
                        win_last_time_reg  <= '0;
                        seeded_reg         <= 1'b0;
                        idle_reg           <= '0;
                        acc_reg            <= '0;
                    end
                    else
                    begin
                        // counter mirror and whole-transfer anchor
                        prev_count_reg <= item_reg.cnt;
                        if (!prev_primed_reg)
                        begin
                            prev_primed_reg <= 1'b1;
                        end
                        else if (item_reg.cnt < prev_count_reg)
                        begin
                            avg_started_reg <= 1'b0;
                        end
                        else if (!avg_started_reg && (item_reg.cnt > prev_count_reg))
                        begin
                            avg_started_reg    <= 1'b1;
                            avg_base_count_reg <= item_reg.cnt;
                            avg_base_time_reg  <= item_reg.now;
                            avg_last_count_reg <= item_reg.cnt;
                            avg_last_time_reg  <= item_reg.now;
                        end
                        else if (avg_started_reg)
                        begin
                            avg_last_count_reg <= item_reg.cnt;
                            avg_last_time_reg  <= item_reg.now;
                        end

                        // windowed tracker
                        if (!win_primed_reg)
                        begin
                            win_primed_reg     <= 1'b1;
                            win_last_count_reg <= item_reg.cnt;
                            win_last_time_reg  <= item_reg.now;
                        end
                        else if (item_reg.cnt < win_last_count_reg)
                        begin
                            win_last_count_reg <= item_reg.cnt;
                            win_last_time_reg  <= item_reg.now;
                            seeded_reg         <= 1'b0;
                            idle_reg           <= '0;
                            acc_reg            <= '0;
                        end
                        else if (ms >= win)
                        begin
                            win_last_count_reg <= item_reg.cnt;
                            win_last_time_reg  <= item_reg.now;
                            if (delta == '0)
                            begin
                                idle_reg <= idle_inc;
                                if (idle_inc >= cfg.idle_limit)
                                begin
                                    acc_reg    <= '0;
                                    seeded_reg <= 1'b0;
                                end
                                else
                                begin
                                    bx_reg    <= '0;
                                    state_reg <= S_BL1;
                                end
                            end
                            else
                            begin
                                idle_reg   <= '0;
                                num_reg    <= delta;
                                den_reg    <= ms;
                                scaled_reg <= 1'b1;
                                is_avg_reg <= 1'b0;
                                state_reg  <= S_MUL;
                            end
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= num_reg * brm_pkg::MS_PER_S;
                    state_reg <= S_DGO;
                end
                S_DGO:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (is_avg_reg)
                        begin
                            avg_ok_reg <= 1'b1;
                            avg_res_reg <= (div_ovf || (div_q[AW-1:brm_pkg::OUT_W] != '0))
                                         ? brm_pkg::OUT_MAX : div_q[brm_pkg::OUT_W-1:0];
                            state_reg <= S_OUT;
                        end
                        else if (!seeded_reg)
                        begin
                            acc_reg    <= inst;
                            seeded_reg <= 1'b1;
                            state_reg  <= S_AVG;
                        end
                        else
                        begin
                            bx_reg    <= inst;
                            state_reg <= S_BL1;
                        end
                    end
                end
                S_BL1:
                begin
                    p1_reg    <= a_clamp * bx_reg;
                    state_reg <= S_BL2;
                end
                S_BL2:
                begin
                    p2_reg    <= b_wt * acc_reg;
                    state_reg <= S_BL3;
                end
                S_BL3:
                begin
                    acc_reg   <= bl_sum[brm_pkg::FRAC_W +: AW];
                    state_reg <= S_AVG;
                end
                S_AVG:
                begin
                    if (avg_started_reg && (el != '0))
                    begin
                        num_reg    <= avg_last_count_reg - avg_base_count_reg;
                        den_reg    <= el;
                        scaled_reg <= 1'b0;
                        is_avg_reg <= 1'b1;
                        state_reg  <= S_MUL;
                    end
                    else
                    begin
                        avg_res_reg <= '0;
                        avg_ok_reg  <= 1'b0;
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_item_reg.smoothed_rate <= acc_reg[AW-1:brm_pkg::FRAC_W];
                        out_item_reg.rate_valid    <= seeded_reg;
                        out_item_reg.average_rate  <= avg_res_reg;
                        out_item_reg.average_valid <= avg_ok_reg;
                        state_reg                  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |-> (state_reg == S_IDLE))
        else $error("item taken while engine busy");

    a_unseeded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !seeded_reg |-> (acc_reg == '0))
        else $error("rate accumulator nonzero while unseeded");

    a_seed_primed: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |-> win_primed_reg)
        else $error("seeded without window baseline");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && out_stall) |=> (state_reg == S_OUT))
        else $error("result dropped over a waiting one");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside wait state");

endmodule
